// File: rtl/core/segment_intersection_core_macros.svh
// Assertion macros shared by the segment intersection RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SEGMENT_INTERSECTION_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sgi_pkg.sv
package sgi_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int PROD_W    = 66;
    localparam int WIDE_W    = 67;
    localparam int THR_W     = 63;
    localparam int PP_LO_W   = 34;
    localparam int PP_HI_W   = WIDE_W - PP_LO_W;
    localparam int NUM_W     = 100;
    localparam int DIV_STEPS = 32;

    // Parallel threshold after reset.
    localparam logic [THR_W-1:0] THR_RESET = 63'd43;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t STAT_HIT      = 2'd0;
    localparam status_t STAT_PARALLEL = 2'd1;
    localparam status_t STAT_MISS     = 2'd2;

    // One request as it moves through the divider chain.
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic                negx;
        logic                negy;
        logic [COORD_W-1:0]  o1x;
        logic [COORD_W-1:0]  o1y;
        logic [WIDE_W-1:0]   dm;
        logic [WIDE_W-1:0]   remx;
        logic [WIDE_W-1:0]   remy;
        logic [DIV_STEPS-1:0] shx;
        logic [DIV_STEPS-1:0] shy;
    } div_t;

endpackage

// File: rtl/core/sgi_div_stage.sv
module sgi_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  sgi_pkg::div_t stage_in,
    output sgi_pkg::div_t stage_out
);

    sgi_pkg::div_t stage_reg;
    sgi_pkg::div_t stage_next;

    logic [sgi_pkg::WIDE_W:0] trial_x;
    logic [sgi_pkg::WIDE_W:0] trial_y;
    logic                     ge_x;
    logic                     ge_y;
    logic [sgi_pkg::WIDE_W:0] diff_x;
    logic [sgi_pkg::WIDE_W:0] diff_y;

    // One restoring step per axis: bring down the next numerator bit,
    // subtract the divisor when it fits, and shift the quotient bit in.
    always_comb
    begin
        trial_x = {stage_in.remx, stage_in.shx[sgi_pkg::DIV_STEPS-1]};
        trial_y = {stage_in.remy, stage_in.shy[sgi_pkg::DIV_STEPS-1]};
        ge_x    = trial_x >= {1'b0, stage_in.dm};
        ge_y    = trial_y >= {1'b0, stage_in.dm};
        diff_x  = trial_x - {1'b0, stage_in.dm};
        diff_y  = trial_y - {1'b0, stage_in.dm};

        stage_next      = stage_in;
        stage_next.remx = ge_x ? diff_x[sgi_pkg::WIDE_W-1:0] : trial_x[sgi_pkg::WIDE_W-1:0];
        stage_next.remy = ge_y ? diff_y[sgi_pkg::WIDE_W-1:0] : trial_y[sgi_pkg::WIDE_W-1:0];
        stage_next.shx  = {stage_in.shx[sgi_pkg::DIV_STEPS-2:0], ge_x};
        stage_next.shy  = {stage_in.shy[sgi_pkg::DIV_STEPS-2:0], ge_y};
    end

    // Stage register, frozen while the pipeline is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: rtl/core/segment_intersection_core.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// request  | in_valid / in_ready       | first_*, second_* start/end x,y (8 x 32)
// result   | out_valid / out_ready     | hit_status (2), cross_x, cross_y (32)
// config   | cfg_wr_en                 | cfg_wr_data: parallel threshold (63)
//
// One request is taken per cycle while in_ready is high; its result is presented once the
// request has passed through six arithmetic stages, a 32-step restoring divider
// (one quotient bit per stage) and the output register, 39 registers in all.
// The whole pipeline advances when the output register is empty or being taken;
// otherwise every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits and loads the threshold with 43.
`include "segment_intersection_core_macros.svh"

module segment_intersection_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           first_start_x,
    input  logic signed [31:0]           first_start_y,
    input  logic signed [31:0]           first_end_x,
    input  logic signed [31:0]           first_end_y,
    input  logic signed [31:0]           second_start_x,
    input  logic signed [31:0]           second_start_y,
    input  logic signed [31:0]           second_end_x,
    input  logic signed [31:0]           second_end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   hit_status,
    output logic signed [31:0]           cross_x,
    output logic signed [31:0]           cross_y,
    input  logic                         cfg_wr_en,
    input  logic [sgi_pkg::THR_W-1:0]    cfg_wr_data
);

    logic adv;

    logic [sgi_pkg::THR_W-1:0] thr_reg;

    // Stage 1: direction vectors and start offset.
    logic                              s1_valid_reg;
    logic signed [sgi_pkg::DIFF_W-1:0] s1_v1x_reg, s1_v1y_reg, s1_v2x_reg, s1_v2y_reg;
    logic signed [sgi_pkg::DIFF_W-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [sgi_pkg::DIFF_W-1:0] s1_v1x_next, s1_v1y_next, s1_v2x_next, s1_v2y_next;
    logic signed [sgi_pkg::DIFF_W-1:0] s1_ax_next, s1_ay_next;
    logic [sgi_pkg::COORD_W-1:0]       s1_o1x_reg, s1_o1y_reg;

    // Stage 2: the six cross products.
    logic                              s2_valid_reg;
    logic signed [sgi_pkg::PROD_W-1:0] s2_d1_reg, s2_d2_reg, s2_t1_reg, s2_t2_reg;
    logic signed [sgi_pkg::PROD_W-1:0] s2_u1_reg, s2_u2_reg;
    logic signed [sgi_pkg::DIFF_W-1:0] s2_v1x_reg, s2_v1y_reg;
    logic [sgi_pkg::COORD_W-1:0]       s2_o1x_reg, s2_o1y_reg;

    // Stage 3: D, tn and un.
    logic                        s3_valid_reg;
    logic [sgi_pkg::WIDE_W-1:0]  s3_d_reg, s3_tn_reg, s3_un_reg;
    logic [sgi_pkg::WIDE_W-1:0]  s3_d_next, s3_tn_next, s3_un_next;
    logic [sgi_pkg::DIFF_W-1:0]  s3_v1x_reg, s3_v1y_reg;
    logic [sgi_pkg::COORD_W-1:0] s3_o1x_reg, s3_o1y_reg;

    // Stage 4: magnitudes with the sign of D folded into tn and un.
    logic                        s4_valid_reg;
    logic [sgi_pkg::WIDE_W-1:0]  s4_dm_reg, s4_tn_reg, s4_un_reg;
    logic [sgi_pkg::WIDE_W-1:0]  s4_dm_next, s4_tn_next, s4_un_next;
    logic [sgi_pkg::DIFF_W-1:0]  s4_mvx_full, s4_mvy_full;
    logic [sgi_pkg::COORD_W-1:0] s4_mvx_reg, s4_mvy_reg;
    logic                        s4_negx_reg, s4_negy_reg;
    logic [sgi_pkg::COORD_W-1:0] s4_o1x_reg, s4_o1y_reg;

    // Stage 5: status decision and partial products of tn * |v1|.
    logic                            s5_valid_reg;
    sgi_pkg::status_t                s5_status_reg;
    sgi_pkg::status_t                s5_status_next;
    logic [sgi_pkg::WIDE_W-1:0]      s5_dm_reg;
    logic [sgi_pkg::PROD_W-1:0]      s5_plx_reg, s5_ply_reg;
    logic [sgi_pkg::PROD_W-2:0]      s5_phx_reg, s5_phy_reg;
    logic                            s5_negx_reg, s5_negy_reg;
    logic [sgi_pkg::COORD_W-1:0]     s5_o1x_reg, s5_o1y_reg;

    // Stage 6: full numerators, loaded as the divider's starting state.
    sgi_pkg::div_t              s6_reg;
    sgi_pkg::div_t              s6_next;
    logic [sgi_pkg::NUM_W-1:0]  s6_numx, s6_numy;

    sgi_pkg::div_t div_pipe [0:sgi_pkg::DIV_STEPS];

    // Output register.
    logic                        out_valid_reg;
    sgi_pkg::status_t            out_status_reg;
    logic [sgi_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [sgi_pkg::COORD_W-1:0] out_x_next, out_y_next;
    sgi_pkg::div_t               div_last;

    // The pipeline moves as a whole whenever the output can take an item.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= sgi_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= div_last.valid;
        end
    end

    // Stage 1 arithmetic: sign-extended differences.
    always_comb
    begin
        s1_v1x_next = {first_end_x[31], first_end_x} - {first_start_x[31], first_start_x};
        s1_v1y_next = {first_end_y[31], first_end_y} - {first_start_y[31], first_start_y};
        s1_v2x_next = {second_end_x[31], second_end_x}
                    - {second_start_x[31], second_start_x};
        s1_v2y_next = {second_end_y[31], second_end_y}
                    - {second_start_y[31], second_start_y};
        s1_ax_next  = {second_start_x[31], second_start_x}
                    - {first_start_x[31], first_start_x};
        s1_ay_next  = {second_start_y[31], second_start_y}
                    - {first_start_y[31], first_start_y};
    end

    // Stage 3 arithmetic: exact differences of products.
    always_comb
    begin
        s3_d_next  = {s2_d1_reg[sgi_pkg::PROD_W-1], s2_d1_reg}
                   - {s2_d2_reg[sgi_pkg::PROD_W-1], s2_d2_reg};
        s3_tn_next = {s2_t1_reg[sgi_pkg::PROD_W-1], s2_t1_reg}
                   - {s2_t2_reg[sgi_pkg::PROD_W-1], s2_t2_reg};
        s3_un_next = {s2_u1_reg[sgi_pkg::PROD_W-1], s2_u1_reg}
                   - {s2_u2_reg[sgi_pkg::PROD_W-1], s2_u2_reg};
    end

    // Stage 4 arithmetic: |D|, sign-corrected numerators and |v1|.
    always_comb
    begin
        if (s3_d_reg[sgi_pkg::WIDE_W-1])
        begin
            s4_dm_next = '0 - s3_d_reg;
            s4_tn_next = '0 - s3_tn_reg;
            s4_un_next = '0 - s3_un_reg;
        end
        else
        begin
            s4_dm_next = s3_d_reg;
            s4_tn_next = s3_tn_reg;
            s4_un_next = s3_un_reg;
        end
        s4_mvx_full = s3_v1x_reg[sgi_pkg::DIFF_W-1] ? ('0 - s3_v1x_reg) : s3_v1x_reg;
        s4_mvy_full = s3_v1y_reg[sgi_pkg::DIFF_W-1] ? ('0 - s3_v1y_reg) : s3_v1y_reg;
    end

    // Stage 5 decision: parallel, miss or hit, with t and u tested by compares.
    always_comb
    begin
        if ((s4_dm_reg == '0) || (s4_dm_reg < {4'b0000, thr_reg}))
        begin
            s5_status_next = sgi_pkg::STAT_PARALLEL;
        end
        else if (s4_tn_reg[sgi_pkg::WIDE_W-1] || s4_un_reg[sgi_pkg::WIDE_W-1]
                 || (s4_tn_reg > s4_dm_reg) || (s4_un_reg > s4_dm_reg))
        begin
            s5_status_next = sgi_pkg::STAT_MISS;
        end
        else
        begin
            s5_status_next = sgi_pkg::STAT_HIT;
        end
    end

    // Stage 6: combine partial products and seed the divider.
    always_comb
    begin
        s6_numx = {{(sgi_pkg::NUM_W-sgi_pkg::PROD_W){1'b0}}, s5_plx_reg}
                + {1'b0, s5_phx_reg, {sgi_pkg::PP_LO_W{1'b0}}};
        s6_numy = {{(sgi_pkg::NUM_W-sgi_pkg::PROD_W){1'b0}}, s5_ply_reg}
                + {1'b0, s5_phy_reg, {sgi_pkg::PP_LO_W{1'b0}}};

        s6_next        = '0;
        s6_next.valid  = s5_valid_reg;
        s6_next.status = s5_status_reg;
        s6_next.negx   = s5_negx_reg;
        s6_next.negy   = s5_negy_reg;
        s6_next.o1x    = s5_o1x_reg;
        s6_next.o1y    = s5_o1y_reg;
        s6_next.dm     = s5_dm_reg;
        s6_next.remx   = s6_numx[sgi_pkg::WIDE_W+sgi_pkg::DIV_STEPS-1:sgi_pkg::DIV_STEPS];
        s6_next.remy   = s6_numy[sgi_pkg::WIDE_W+sgi_pkg::DIV_STEPS-1:sgi_pkg::DIV_STEPS];
        s6_next.shx    = s6_numx[sgi_pkg::DIV_STEPS-1:0];
        s6_next.shy    = s6_numy[sgi_pkg::DIV_STEPS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_reg <= '0;
        end
        else if (adv)
        begin
            s6_reg <= s6_next;
        end
    end

    // Payload registers of stages 1 to 5.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_v1x_reg <= s1_v1x_next;
            s1_v1y_reg <= s1_v1y_next;
            s1_v2x_reg <= s1_v2x_next;
            s1_v2y_reg <= s1_v2y_next;
            s1_ax_reg  <= s1_ax_next;
            s1_ay_reg  <= s1_ay_next;
            s1_o1x_reg <= first_start_x;
            s1_o1y_reg <= first_start_y;

            s2_d1_reg  <= s1_v1x_reg * s1_v2y_reg;
            s2_d2_reg  <= s1_v1y_reg * s1_v2x_reg;
            s2_t1_reg  <= s1_ax_reg * s1_v2y_reg;
            s2_t2_reg  <= s1_ay_reg * s1_v2x_reg;
            s2_u1_reg  <= s1_ax_reg * s1_v1y_reg;
            s2_u2_reg  <= s1_ay_reg * s1_v1x_reg;
            s2_v1x_reg <= s1_v1x_reg;
            s2_v1y_reg <= s1_v1y_reg;
            s2_o1x_reg <= s1_o1x_reg;
            s2_o1y_reg <= s1_o1y_reg;

            s3_d_reg   <= s3_d_next;
            s3_tn_reg  <= s3_tn_next;
            s3_un_reg  <= s3_un_next;
            s3_v1x_reg <= s2_v1x_reg;
            s3_v1y_reg <= s2_v1y_reg;
            s3_o1x_reg <= s2_o1x_reg;
            s3_o1y_reg <= s2_o1y_reg;

            s4_dm_reg   <= s4_dm_next;
            s4_tn_reg   <= s4_tn_next;
            s4_un_reg   <= s4_un_next;
            s4_mvx_reg  <= s4_mvx_full[sgi_pkg::COORD_W-1:0];
            s4_mvy_reg  <= s4_mvy_full[sgi_pkg::COORD_W-1:0];
            s4_negx_reg <= s3_v1x_reg[sgi_pkg::DIFF_W-1];
            s4_negy_reg <= s3_v1y_reg[sgi_pkg::DIFF_W-1];
            s4_o1x_reg  <= s3_o1x_reg;
            s4_o1y_reg  <= s3_o1y_reg;

            s5_status_reg <= s5_status_next;
            s5_dm_reg     <= s4_dm_reg;
            s5_plx_reg    <= s4_tn_reg[sgi_pkg::PP_LO_W-1:0] * s4_mvx_reg;
            s5_phx_reg    <= s4_tn_reg[sgi_pkg::WIDE_W-1:sgi_pkg::PP_LO_W] * s4_mvx_reg;
            s5_ply_reg    <= s4_tn_reg[sgi_pkg::PP_LO_W-1:0] * s4_mvy_reg;
            s5_phy_reg    <= s4_tn_reg[sgi_pkg::WIDE_W-1:sgi_pkg::PP_LO_W] * s4_mvy_reg;
            s5_negx_reg   <= s4_negx_reg;
            s5_negy_reg   <= s4_negy_reg;
            s5_o1x_reg    <= s4_o1x_reg;
            s5_o1y_reg    <= s4_o1y_reg;
        end
    end

    // Divider chain: one quotient bit per stage for both axes.
    assign div_pipe[0] = s6_reg;

    for (genvar k = 0; k < sgi_pkg::DIV_STEPS; k++)
    begin : g_div
        sgi_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .stage_in  (div_pipe[k]),
            .stage_out (div_pipe[k+1])
        );
    end

    assign div_last = div_pipe[sgi_pkg::DIV_STEPS];

    // Final point: start plus or minus the quotient, zero unless a hit.
    always_comb
    begin
        if (div_last.status != sgi_pkg::STAT_HIT)
        begin
            out_x_next = '0;
            out_y_next = '0;
        end
        else
        begin
            out_x_next = div_last.negx ? (div_last.o1x - div_last.shx)
                                       : (div_last.o1x + div_last.shx);
            out_y_next = div_last.negy ? (div_last.o1y - div_last.shy)
                                       : (div_last.o1y + div_last.shy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_status_reg <= div_last.status;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit_status = out_status_reg;
    assign cross_x    = out_x_reg;
    assign cross_y    = out_y_reg;

    // Checks on the pipeline's own logic.
    `SGI_ASSERT_IMP(a_nohit_zero, out_valid_reg && (out_status_reg != sgi_pkg::STAT_HIT),
        (out_x_reg == '0) && (out_y_reg == '0), "non-hit result carries a nonzero point")
    `SGI_ASSERT_NXT(a_stall_holds, !adv,
        $stable(s6_reg.valid) && $stable(s5_valid_reg) && $stable(out_valid_reg),
        "pipeline valid bits moved during a stall")
    `SGI_ASSERT_IMP(a_div_seed, s6_reg.valid && (s6_reg.status == sgi_pkg::STAT_HIT),
        (s6_reg.remx < s6_reg.dm) && (s6_reg.remy < s6_reg.dm),
        "divider seed overflows the 32-bit quotient")
    `SGI_ASSERT_NXT(a_accept_enters, in_valid && in_ready, s1_valid_reg,
        "accepted request did not enter the pipeline")

endmodule
